FILE: rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 (BMP) converter.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// Queue between the decode front and the serializing back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Lead and continuation byte classification
	localparam logic [7:0] MASK_ASCII = 8'h80;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] PAT_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] PAT_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] PAT_LEAD4  = 8'hF0;
	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] PAT_CONT   = 8'h80;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

	// Continuation bytes still expected
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	localparam logic BIG_ENDIAN_RESET = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       unit_last;
		logic       error_flag;
	} out_word_t;

	// One decoded code unit or an error marker
	typedef struct packed {
		logic [15:0] code;
		logic        err;
	} unit_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

FILE: rtl/core/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 words, tracks the open sequence and pushes code units.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     src_valid,
	output logic                     src_ready,
	input  u8u16_pkg::in_word_t      src_data,
	input  u8u16_pkg::queue_status_t q_status,
	output logic                     push,
	output u8u16_pkg::unit_t         push_unit
);
	import u8u16_pkg::*;

	logic [15:0] acc_q;
	logic [1:0]  pend_q;
	logic        halted_q;

	logic [15:0] acc_d;
	logic [1:0]  pend_d;
	logic        halted_d;
	logic        emit_unit;
	logic        emit_err;
	logic [15:0] unit_code;
	logic [15:0] acc_shift;
	logic        accept;
	logic [7:0]  b;
	logic        last;

	assign src_ready = !q_status.full;
	assign accept    = src_valid && src_ready;
	assign b         = src_data.in_byte;
	assign last      = src_data.in_last;
	assign acc_shift = {acc_q[9:0], b[5:0] & CONT_BITS[5:0]};

	always_comb begin
		acc_d     = acc_q;
		pend_d    = pend_q;
		halted_d  = halted_q;
		emit_unit = 1'b0;
		emit_err  = 1'b0;
		unit_code = 16'h0000;
		if (halted_q) begin
			// drop until the end of the string
			if (last) begin
				halted_d = 1'b0;
			end
		end else if (pend_q == PEND_NONE) begin
			if ((b & MASK_ASCII) == 8'h00) begin
				emit_unit = 1'b1;
				unit_code = {8'h00, b};
				acc_d     = 16'h0000;
			end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
				acc_d  = {11'd0, b[4:0]};
				pend_d = PEND_ONE;
				emit_err = last;
			end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
				acc_d  = {12'd0, b[3:0]};
				pend_d = PEND_TWO;
				emit_err = last;
			end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
				acc_d  = {13'd0, b[2:0]};
				pend_d = PEND_THREE;
				emit_err = last;
			end else begin
				emit_err = 1'b1;
			end
		end else begin
			if ((b & MASK_CONT) != PAT_CONT) begin
				emit_err = 1'b1;
			end else if (pend_q == PEND_ONE) begin
				emit_unit = 1'b1;
				unit_code = acc_shift;
				acc_d     = 16'h0000;
				pend_d    = PEND_NONE;
			end else begin
				acc_d    = acc_shift;
				pend_d   = pend_q - 2'd1;
				emit_err = last;
			end
		end
		if (emit_err) begin
			acc_d    = 16'h0000;
			pend_d   = PEND_NONE;
			halted_d = !last;
		end
	end

	assign push           = accept && !halted_q && (emit_unit || emit_err);
	assign push_unit.code = emit_err ? 16'h0000 : unit_code;
	assign push_unit.err  = emit_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pend_q   <= PEND_NONE;
			halted_q <= 1'b0;
		end else if (accept) begin
			acc_q    <= acc_d;
			pend_q   <= pend_d;
			halted_q <= halted_d;
		end
	end

endmodule

FILE: rtl/core/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of code units between the decode front and the serializer.
// ----------------------------------------------------------------------------
module u8u16_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  u8u16_pkg::unit_t         push_unit,
	input  logic                     pop,
	output u8u16_pkg::unit_t         head,
	output u8u16_pkg::queue_status_t status
);
	import u8u16_pkg::*;

	unit_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_PTR_W-1:0] PTR_ONE  = QUEUE_PTR_W'(1);
	localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
	localparam logic [QUEUE_CNT_W-1:0] CNT_ONE  = QUEUE_CNT_W'(1);

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_FULL);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue pop while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

FILE: rtl/core/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Serializes each queued code unit into two output words.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     big_endian,
	input  u8u16_pkg::unit_t         head,
	input  u8u16_pkg::queue_status_t q_status,
	output logic                     pop,
	output logic                     dst_valid,
	input  logic                     dst_ready,
	output u8u16_pkg::out_word_t     dst_data
);
	import u8u16_pkg::*;

	unit_t unit_q;
	logic  busy_q;
	logic  phase_q;
	logic  sent;
	logic  sel_hi;

	assign dst_valid = busy_q;
	assign sent      = busy_q && dst_ready;
	assign pop       = !q_status.empty && (!busy_q || (sent && phase_q));

	// first word takes the high byte in big-endian order
	assign sel_hi              = big_endian ^ phase_q;
	assign dst_data.out_byte   = sel_hi ? unit_q.code[15:8] : unit_q.code[7:0];
	assign dst_data.unit_last  = phase_q;
	assign dst_data.error_flag = unit_q.err;

	always_ff @(posedge clk) begin
		if (pop) begin
			unit_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (sent) begin
			busy_q  <= !phase_q;
			phase_q <= !phase_q;
		end
	end

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_ready && !dst_data.unit_last) |=> (dst_valid && dst_data.unit_last))
		else $error("second word of a pair missing");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.error_flag) |-> (dst_data.out_byte == 8'h00))
		else $error("error marker carries nonzero byte");

endmodule

FILE: rtl/core/utf8_to_utf16_converter_top.sv
// Path: a completed code unit goes through the queue and the serializer; the
//   second output word follows in the cycle after the first is taken.
// Throughput: one input word per cycle while the queue is not full; each code
//   unit takes two output words, so the output serializer sets the rate.
// Reset: arst_n clears the decode state, the queue and the serializer; big_endian
//   returns to 1.
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_top
// UTF-8 byte stream to UTF-16 (BMP) code units, two output words per unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  u8u16_pkg::in_word_t  src_data,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output u8u16_pkg::out_word_t dst_data,
	input  logic                 cfg_we,
	input  logic                 cfg_data
);
	import u8u16_pkg::*;

	// Byte order register; the user must write it only while the converter is idle (not enforced here)
	logic big_endian_q;

	// Front to queue
	logic  push;
	unit_t push_unit;

	// Queue to back
	logic          pop;
	unit_t         head;
	queue_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= BIG_ENDIAN_RESET;
		end else if (cfg_we) begin
			big_endian_q <= cfg_data;
		end
	end

	// Front: classify each word, gather continuation bits, detect errors.
	// It stalls only when the queue is full.
	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.q_status  (q_status),
		.push      (push),
		.push_unit (push_unit)
	);

	// Queue: decouples the decoder from output backpressure
	u8u16_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_unit (push_unit),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Back: hold one unit and send its two bytes in the configured order.
	// If a unit is queued, the next unit loads in the same cycle the second word is taken.
	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.big_endian (big_endian_q),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_ready  (dst_ready),
		.dst_data   (dst_data)
	);

endmodule
